@@ hdl/instability_time_monitor_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Instability time monitor assertion macros
// Shared concurrent assertion forms for the monitor's checker.
// ----------------------------------------------------------------------------
`ifndef INSTABILITY_TIME_MONITOR_UNIT_ASSERT_SVH
`define INSTABILITY_TIME_MONITOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITMU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("instability monitor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("instability monitor assertion failed");

`endif

@@ hdl/itmu_pkg.sv @@
// ----------------------------------------------------------------------------
// Instability time monitor package
// Types, codes and helper functions shared by the monitor's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package itmu_pkg;

   localparam int NUM_CHANNELS = 5;
   localparam int SAMPLE_BITS  = 16;
   localparam int LEVEL_BITS   = 15;
   localparam int LIMIT_BITS   = 20;
   localparam int ACC_BITS     = LIMIT_BITS + 1;
   localparam int STATUS_BITS  = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_WARN  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ERROR = 2'd2;

   localparam logic KIND_CHECK = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIME_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WHEEL_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEG_LIMIT   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILT_LIMIT  = 2'd3;

   localparam logic [LIMIT_BITS-1:0] TIME_LIMIT_RESET  = 20'd10000;
   localparam logic [LEVEL_BITS-1:0] WHEEL_LIMIT_RESET = 15'd10240;
   localparam logic [LEVEL_BITS-1:0] LEG_LIMIT_RESET   = 15'd5120;
   localparam logic [LEVEL_BITS-1:0] TILT_LIMIT_RESET  = 15'd313;

   localparam int CH_LEFT_WHEEL  = 0;
   localparam int CH_RIGHT_WHEEL = 1;
   localparam int CH_LEFT_LEG    = 2;
   localparam int CH_RIGHT_LEG   = 3;
   localparam int CH_TILT        = 4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic                  update;
      logic                  clear;
      logic [LIMIT_BITS-1:0] time_limit;
      logic [ACC_BITS-1:0]   elapsed;
   } chan_ctrl_type;

   function automatic logic [SAMPLE_BITS:0] magnitude(input sample_type value);
      logic [SAMPLE_BITS:0] ext;
      ext = {1'b0, value};
      if (value[SAMPLE_BITS-1]) begin
         return {1'b1, {SAMPLE_BITS{1'b0}}} - ext;
      end
      return ext;
   endfunction

endpackage

`default_nettype wire

@@ hdl/itmu_channel.sv @@
// ----------------------------------------------------------------------------
// Instability time monitor channel
// Accumulator, error latch and error counter of one monitored measurement.
// ----------------------------------------------------------------------------
`default_nettype none

module itmu_channel #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire itmu_pkg::chan_ctrl_type          ctrl,
   input  wire logic                             trig,
   output logic [itmu_pkg::STATUS_BITS-1:0]      status_in,
   output logic [COUNT_BITS-1:0]                 count_in
);
   import itmu_pkg::*;

   localparam int SUM_BITS = ACC_BITS + 1;

   logic [ACC_BITS-1:0]   acc_ff;
   logic [ACC_BITS-1:0]   acc_in;
   logic                  latch_ff;
   logic                  latch_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [SUM_BITS-1:0]   sum;
   logic [SUM_BITS-1:0]   limit_ext;

   always_comb begin
      limit_ext = SUM_BITS'(ctrl.time_limit);
      if (trig) begin
         sum = SUM_BITS'(acc_ff) + SUM_BITS'(ctrl.elapsed);
      end else if (acc_ff > ctrl.elapsed) begin
         sum = SUM_BITS'(acc_ff - ctrl.elapsed);
      end else begin
         sum = '0;
      end
      acc_in    = sum[ACC_BITS-1:0];
      latch_in  = 1'b0;
      count_in  = count_ff;
      status_in = STATUS_OK;
      if (ctrl.clear) begin
         acc_in   = '0;
         count_in = '0;
      end else if (sum > limit_ext) begin
         acc_in    = ACC_BITS'(ctrl.time_limit) + ACC_BITS'(1);
         status_in = STATUS_ERROR;
         latch_in  = 1'b1;
         if (!latch_ff && (count_ff != '1)) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end else if (sum > (limit_ext >> 1)) begin
         status_in = STATUS_WARN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         latch_ff <= 1'b0;
         count_ff <= '0;
      end else if (ctrl.update) begin
         acc_ff   <= acc_in;
         latch_ff <= latch_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/instability_time_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// Instability time monitor unit
// Watches five measurements over time and flags sustained instability.
// ----------------------------------------------------------------------------
// Usage:
// Check and reset items arrive on the req_ channel and are accepted when
// req_valid is high and req_stall is low. Each item yields exactly one result
// on the rsp_ channel, accepted when rsp_valid is high and rsp_stall is low.
// An accepted item is held in an input register; once the output register can
// take it, the five channels are updated in parallel and the result is loaded
// there. One item is taken per cycle while rsp_stall is low. The user must write
// the limits through the csr_ port only while no item is in flight; the block
// does not enforce it. When the receiver stalls, the result stays in the
// output register and one more item may wait in the input register; after
// that req_stall is raised. Reset empties both registers, restores the default
// limits and clears all channel state, the sticky instability flag and the
// initialized bit, so the next check item restarts the time base.
// ----------------------------------------------------------------------------
`default_nettype none

module instability_time_monitor_unit #(
   parameter int TIME_BITS  = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [itmu_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [itmu_pkg::LIMIT_BITS-1:0]      csr_wdata,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_kind,
   input  wire logic [TIME_BITS-1:0]                 req_now_us,
   input  wire itmu_pkg::sample_type                 req_left_wheel_speed,
   input  wire itmu_pkg::sample_type                 req_right_wheel_speed,
   input  wire itmu_pkg::sample_type                 req_left_leg_rate,
   input  wire itmu_pkg::sample_type                 req_right_leg_rate,
   input  wire itmu_pkg::sample_type                 req_body_tilt,
   input  wire logic                                 req_deforced_mode,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [itmu_pkg::STATUS_BITS-1:0]          rsp_left_wheel_status,
   output logic [itmu_pkg::STATUS_BITS-1:0]          rsp_right_wheel_status,
   output logic [itmu_pkg::STATUS_BITS-1:0]          rsp_left_leg_status,
   output logic [itmu_pkg::STATUS_BITS-1:0]          rsp_right_leg_status,
   output logic [itmu_pkg::STATUS_BITS-1:0]          rsp_tilt_status,
   output logic                                      rsp_instable,
   output logic [COUNT_BITS-1:0]                     rsp_left_wheel_errors,
   output logic [COUNT_BITS-1:0]                     rsp_right_wheel_errors,
   output logic [COUNT_BITS-1:0]                     rsp_left_leg_errors,
   output logic [COUNT_BITS-1:0]                     rsp_right_leg_errors,
   output logic [COUNT_BITS-1:0]                     rsp_tilt_errors
);
   import itmu_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > ACC_BITS) ? TIME_BITS : ACC_BITS;

   logic [LIMIT_BITS-1:0]  time_limit_ff;
   logic [LEVEL_BITS-1:0]  wheel_limit_ff;
   logic [LEVEL_BITS-1:0]  leg_limit_ff;
   logic [LEVEL_BITS-1:0]  tilt_limit_ff;

   logic                   s1_valid_ff;
   logic                   s1_kind_ff;
   logic [TIME_BITS-1:0]   s1_now_ff;
   sample_type             s1_sample_ff [NUM_CHANNELS];
   logic                   s1_deforced_ff;

   logic [TIME_BITS-1:0]   last_time_ff;
   logic                   initialized_ff;
   logic                   instable_ff;
   logic                   instable_in;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] status_ff [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]  count_ff  [NUM_CHANNELS];
   logic                   rsp_instable_ff;

   logic                   advance;
   logic                   fire;
   logic [TIME_BITS-1:0]   elapsed_full;
   logic [CMP_BITS-1:0]    elapsed_cmp;
   logic                   long_gap;
   logic [LEVEL_BITS-1:0]  level [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] trig;
   logic [NUM_CHANNELS-1:0] error_now;
   chan_ctrl_type          ctrl;
   logic [STATUS_BITS-1:0] status_in [NUM_CHANNELS];
   logic [COUNT_BITS-1:0]  count_in  [NUM_CHANNELS];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_limit_ff  <= TIME_LIMIT_RESET;
         wheel_limit_ff <= WHEEL_LIMIT_RESET;
         leg_limit_ff   <= LEG_LIMIT_RESET;
         tilt_limit_ff  <= TILT_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TIME_LIMIT:  time_limit_ff  <= csr_wdata;
            CSR_WHEEL_LIMIT: wheel_limit_ff <= csr_wdata[LEVEL_BITS-1:0];
            CSR_LEG_LIMIT:   leg_limit_ff   <= csr_wdata[LEVEL_BITS-1:0];
            CSR_TILT_LIMIT:  tilt_limit_ff  <= csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_kind_ff                     <= req_kind;
         s1_now_ff                      <= req_now_us;
         s1_sample_ff[CH_LEFT_WHEEL]    <= req_left_wheel_speed;
         s1_sample_ff[CH_RIGHT_WHEEL]   <= req_right_wheel_speed;
         s1_sample_ff[CH_LEFT_LEG]      <= req_left_leg_rate;
         s1_sample_ff[CH_RIGHT_LEG]     <= req_right_leg_rate;
         s1_sample_ff[CH_TILT]          <= req_body_tilt;
         s1_deforced_ff                 <= req_deforced_mode;
      end
   end

   always_comb begin
      level[CH_LEFT_WHEEL]  = wheel_limit_ff;
      level[CH_RIGHT_WHEEL] = wheel_limit_ff;
      level[CH_LEFT_LEG]    = leg_limit_ff;
      level[CH_RIGHT_LEG]   = leg_limit_ff;
      level[CH_TILT]        = tilt_limit_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         trig[i] = magnitude(s1_sample_ff[i]) > (SAMPLE_BITS + 1)'(level[i]);
      end
      trig[CH_TILT] = trig[CH_TILT] && !s1_deforced_ff;

      elapsed_full = s1_now_ff - last_time_ff;
      elapsed_cmp  = CMP_BITS'(elapsed_full);
      long_gap     = elapsed_cmp > CMP_BITS'({time_limit_ff, 1'b0});

      ctrl.update     = fire;
      ctrl.clear      = (s1_kind_ff == KIND_RESET) || !initialized_ff || long_gap;
      ctrl.time_limit = time_limit_ff;
      ctrl.elapsed    = elapsed_cmp[ACC_BITS-1:0];
   end

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
      itmu_channel #(
         .COUNT_BITS (COUNT_BITS)
      ) u_channel (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .trig      (trig[g]),
         .status_in (status_in[g]),
         .count_in  (count_in[g])
      );
      assign error_now[g] = (status_in[g] == STATUS_ERROR);
   end

   assign instable_in = (s1_kind_ff == KIND_RESET) ? 1'b0 : (instable_ff || (|error_now));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff   <= '0;
         initialized_ff <= 1'b0;
         instable_ff    <= 1'b0;
      end else if (fire) begin
         last_time_ff <= s1_now_ff;
         instable_ff  <= instable_in;
         if (s1_kind_ff == KIND_CHECK) begin
            initialized_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff       <= status_in;
         count_ff        <= count_in;
         rsp_instable_ff <= instable_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_left_wheel_status  = status_ff[CH_LEFT_WHEEL];
   assign rsp_right_wheel_status = status_ff[CH_RIGHT_WHEEL];
   assign rsp_left_leg_status    = status_ff[CH_LEFT_LEG];
   assign rsp_right_leg_status   = status_ff[CH_RIGHT_LEG];
   assign rsp_tilt_status        = status_ff[CH_TILT];
   assign rsp_instable           = rsp_instable_ff;
   assign rsp_left_wheel_errors  = count_ff[CH_LEFT_WHEEL];
   assign rsp_right_wheel_errors = count_ff[CH_RIGHT_WHEEL];
   assign rsp_left_leg_errors    = count_ff[CH_LEFT_LEG];
   assign rsp_right_leg_errors   = count_ff[CH_RIGHT_LEG];
   assign rsp_tilt_errors        = count_ff[CH_TILT];

endmodule

`default_nettype wire

@@ hdl/itmu_checker.sv @@
// ----------------------------------------------------------------------------
// Instability time monitor checker
// Port-level assertions on the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "instability_time_monitor_unit_assert.svh"

module itmu_checker #(
   parameter int COUNT_BITS = 16
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [itmu_pkg::STATUS_BITS-1:0] rsp_left_wheel_status,
   input wire logic [itmu_pkg::STATUS_BITS-1:0] rsp_right_wheel_status,
   input wire logic [itmu_pkg::STATUS_BITS-1:0] rsp_left_leg_status,
   input wire logic [itmu_pkg::STATUS_BITS-1:0] rsp_right_leg_status,
   input wire logic [itmu_pkg::STATUS_BITS-1:0] rsp_tilt_status,
   input wire logic                             rsp_instable,
   input wire logic [COUNT_BITS-1:0]            rsp_left_wheel_errors
);
   import itmu_pkg::*;

   logic any_error;

   assign any_error = (rsp_left_wheel_status == STATUS_ERROR)
                   || (rsp_right_wheel_status == STATUS_ERROR)
                   || (rsp_left_leg_status == STATUS_ERROR)
                   || (rsp_right_leg_status == STATUS_ERROR)
                   || (rsp_tilt_status == STATUS_ERROR);

   `ITMU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_left_wheel_errors))
   `ITMU_ASSERT_SAME(a_error_sets_flag, clock, reset, rsp_valid && any_error, rsp_instable)
   `ITMU_ASSERT_SAME(a_error_counted, clock, reset, rsp_valid && (rsp_left_wheel_status == STATUS_ERROR), rsp_left_wheel_errors != '0)
   `ITMU_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind instability_time_monitor_unit itmu_checker #(.COUNT_BITS(COUNT_BITS)) u_itmu_checker (.*);

`default_nettype wire

@@ sim/instability_time_monitor_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instability time monitor checker
// Watches the limit writes and both item channels of the monitor, keeps its
// own copy of the channel accumulators, counts and sticky flag, predicts one
// report per accepted item and compares each delivered report field by field.
// ----------------------------------------------------------------------------
module instability_time_monitor_unit_checker (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     csr_write,
   input  logic [itmu_pkg::CSR_INDEX_BITS-1:0]                      csr_index,
   input  logic [itmu_pkg::LIMIT_BITS-1:0]                          csr_wdata,
   input  logic                                                     req_valid,
   input  logic                                                     req_stall,
   input  logic                                                     req_kind,
   input  logic [31:0]                                              req_now_us,
   input  logic [itmu_pkg::NUM_CHANNELS-1:0][itmu_pkg::SAMPLE_BITS-1:0] req_levels,
   input  logic                                                     req_deforced_mode,
   input  logic                                                     rsp_valid,
   input  logic                                                     rsp_stall,
   input  logic [itmu_pkg::NUM_CHANNELS-1:0][itmu_pkg::STATUS_BITS-1:0] rsp_status,
   input  logic                                                     rsp_instable,
   input  logic [itmu_pkg::NUM_CHANNELS-1:0][15:0]                  rsp_errors,
   output int                                                       mismatches,
   output int                                                       outstanding,
   output int                                                       items_seen,
   output int                                                       results_seen
);
   import itmu_pkg::*;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0][STATUS_BITS-1:0] status;
      logic                                     instable;
      logic [NUM_CHANNELS-1:0][15:0]            errors;
   } monitor_report_type;

   string chan_name [NUM_CHANNELS] = '{"left wheel", "right wheel", "left leg",
                                       "right leg", "tilt"};

   logic [LIMIT_BITS-1:0]  time_limit;
   logic [LEVEL_BITS-1:0]  wheel_limit;
   logic [LEVEL_BITS-1:0]  leg_limit;
   logic [LEVEL_BITS-1:0]  tilt_limit;
   logic [31:0]            last_time;
   logic                   initialized;
   logic                   instable_flag;
   logic [ACC_BITS-1:0]    acc [NUM_CHANNELS];
   logic [STATUS_BITS-1:0] chan_status [NUM_CHANNELS];
   logic                   error_latched [NUM_CHANNELS];
   logic [15:0]            error_count [NUM_CHANNELS];

   monitor_report_type pending_reports [$];
   monitor_report_type fresh_report;
   monitor_report_type seen_report;

   function automatic logic [SAMPLE_BITS:0] level_magnitude(input logic [SAMPLE_BITS-1:0] raw);
      logic [SAMPLE_BITS:0] wide;
      wide = {raw[SAMPLE_BITS-1], raw};
      return raw[SAMPLE_BITS-1] ? ~wide + 1'b1 : wide;
   endfunction

   task automatic clear_channels(input logic [31:0] now);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         acc[c] = '0;
         chan_status[c] = STATUS_OK;
         error_latched[c] = 1'b0;
         error_count[c] = '0;
      end
      last_time = now;
   endtask

   task automatic advance_monitor(input logic kind, input logic [31:0] now,
                                  input logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] levels,
                                  input logic deforced, output monitor_report_type report);
      logic [NUM_CHANNELS-1:0] hot;
      logic [31:0]             elapsed;
      logic [ACC_BITS+1:0]     sum;
      if (kind == KIND_RESET) begin
         instable_flag = 1'b0;
         clear_channels(now);
      end else begin
         if (!initialized) begin
            clear_channels(now);
            initialized = 1'b1;
         end
         hot[CH_LEFT_WHEEL]  = level_magnitude(levels[CH_LEFT_WHEEL]) > wheel_limit;
         hot[CH_RIGHT_WHEEL] = level_magnitude(levels[CH_RIGHT_WHEEL]) > wheel_limit;
         hot[CH_LEFT_LEG]    = level_magnitude(levels[CH_LEFT_LEG]) > leg_limit;
         hot[CH_RIGHT_LEG]   = level_magnitude(levels[CH_RIGHT_LEG]) > leg_limit;
         hot[CH_TILT]        = (level_magnitude(levels[CH_TILT]) > tilt_limit) && !deforced;
         elapsed = now - last_time;
         if (elapsed > {time_limit, 1'b0}) begin
            // A gap this long restarts every channel but keeps the sticky flag.
            clear_channels(now);
         end else begin
            last_time = now;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (hot[c]) begin
                  sum = (ACC_BITS+2)'(acc[c] + elapsed);
               end else if (acc[c] > elapsed) begin
                  sum = (ACC_BITS+2)'(acc[c] - elapsed);
               end else begin
                  sum = '0;
               end
               if (sum > time_limit) begin
                  sum = (ACC_BITS+2)'(time_limit) + 1'b1;
                  chan_status[c] = STATUS_ERROR;
                  if (!error_latched[c]) begin
                     if (error_count[c] != 16'hFFFF) begin
                        error_count[c] = error_count[c] + 1'b1;
                     end
                     error_latched[c] = 1'b1;
                  end
                  instable_flag = 1'b1;
               end else if (sum > (time_limit >> 1)) begin
                  chan_status[c] = STATUS_WARN;
                  error_latched[c] = 1'b0;
               end else begin
                  chan_status[c] = STATUS_OK;
                  error_latched[c] = 1'b0;
               end
               acc[c] = sum[ACC_BITS-1:0];
            end
         end
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         report.status[c] = chan_status[c];
         report.errors[c] = error_count[c];
      end
      report.instable = instable_flag;
   endtask

   task automatic compare_report(input monitor_report_type want,
                                 input monitor_report_type got);
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (want.status[c] !== got.status[c]) begin
            $display("%0t: %s status expected %0d, got %0d", $time, chan_name[c],
                     want.status[c], got.status[c]);
            mismatches++;
         end
         if (want.errors[c] !== got.errors[c]) begin
            $display("%0t: %s error count expected %0d, got %0d", $time, chan_name[c],
                     want.errors[c], got.errors[c]);
            mismatches++;
         end
      end
      if (want.instable !== got.instable) begin
         $display("%0t: instable flag expected %0d, got %0d", $time, want.instable,
                  got.instable);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         time_limit = TIME_LIMIT_RESET;
         wheel_limit = WHEEL_LIMIT_RESET;
         leg_limit = LEG_LIMIT_RESET;
         tilt_limit = TILT_LIMIT_RESET;
         clear_channels('0);
         initialized = 1'b0;
         instable_flag = 1'b0;
         pending_reports.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TIME_LIMIT:  time_limit = csr_wdata;
               CSR_WHEEL_LIMIT: wheel_limit = csr_wdata[LEVEL_BITS-1:0];
               CSR_LEG_LIMIT:   leg_limit = csr_wdata[LEVEL_BITS-1:0];
               CSR_TILT_LIMIT:  tilt_limit = csr_wdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            seen_report.status = rsp_status;
            seen_report.instable = rsp_instable;
            seen_report.errors = rsp_errors;
            if (pending_reports.size() == 0) begin
               $display("%0t: report delivered with no item outstanding", $time);
               mismatches++;
            end else begin
               compare_report(pending_reports.pop_front(), seen_report);
            end
         end
         if (req_valid && !req_stall) begin
            items_seen++;
            advance_monitor(req_kind, req_now_us, req_levels, req_deforced_mode, fresh_report);
            pending_reports.push_back(fresh_report);
         end
      end
      outstanding = pending_reports.size();
   end

endmodule

@@ sim/instability_time_monitor_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instability time monitor testbench
// Drives a directed sequence and then randomized phases of check and reset
// items under several limit settings and idle patterns, including a long
// receiver hold-off, while a checker module predicts and compares reports.
// ----------------------------------------------------------------------------
module instability_time_monitor_unit_tb;
   import itmu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 140;
   localparam int PHASE_COUNT = 8;

   logic                                     clock = 1'b0;
   logic                                     reset = 1'b1;
   logic                                     csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]                csr_index = CSR_TIME_LIMIT;
   logic [LIMIT_BITS-1:0]                    csr_wdata = '0;
   logic                                     req_valid = 1'b0;
   logic                                     req_kind = KIND_CHECK;
   logic [31:0]                              req_now_us = '0;
   logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] req_levels = '0;
   logic                                     req_deforced_mode = 1'b0;
   logic                                     rsp_stall = 1'b0;
   wire                                      req_stall;
   wire                                      rsp_valid;
   wire                                      rsp_instable;
   wire  [NUM_CHANNELS-1:0][STATUS_BITS-1:0] rsp_status;
   wire  [NUM_CHANNELS-1:0][15:0]            rsp_errors;

   int mismatches;
   int outstanding;
   int items_seen;
   int results_seen;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;

   logic [31:0]             stim_now;
   logic [NUM_CHANNELS-1:0] hot = '0;
   logic [LIMIT_BITS-1:0]   time_lim = TIME_LIMIT_RESET;
   logic [LEVEL_BITS-1:0]   wheel_lim = WHEEL_LIMIT_RESET;
   logic [LEVEL_BITS-1:0]   leg_lim = LEG_LIMIT_RESET;
   logic [LEVEL_BITS-1:0]   tilt_lim = TILT_LIMIT_RESET;

   instability_time_monitor_unit u_top (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_now_us             (req_now_us),
      .req_left_wheel_speed   (req_levels[CH_LEFT_WHEEL]),
      .req_right_wheel_speed  (req_levels[CH_RIGHT_WHEEL]),
      .req_left_leg_rate      (req_levels[CH_LEFT_LEG]),
      .req_right_leg_rate     (req_levels[CH_RIGHT_LEG]),
      .req_body_tilt          (req_levels[CH_TILT]),
      .req_deforced_mode      (req_deforced_mode),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_left_wheel_status  (rsp_status[CH_LEFT_WHEEL]),
      .rsp_right_wheel_status (rsp_status[CH_RIGHT_WHEEL]),
      .rsp_left_leg_status    (rsp_status[CH_LEFT_LEG]),
      .rsp_right_leg_status   (rsp_status[CH_RIGHT_LEG]),
      .rsp_tilt_status        (rsp_status[CH_TILT]),
      .rsp_instable           (rsp_instable),
      .rsp_left_wheel_errors  (rsp_errors[CH_LEFT_WHEEL]),
      .rsp_right_wheel_errors (rsp_errors[CH_RIGHT_WHEEL]),
      .rsp_left_leg_errors    (rsp_errors[CH_LEFT_LEG]),
      .rsp_right_leg_errors   (rsp_errors[CH_RIGHT_LEG]),
      .rsp_tilt_errors        (rsp_errors[CH_TILT])
   );

   instability_time_monitor_unit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_now_us        (req_now_us),
      .req_levels        (req_levels),
      .req_deforced_mode (req_deforced_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_instable      (rsp_instable),
      .rsp_errors        (rsp_errors),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .items_seen        (items_seen),
      .results_seen      (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver stalls at random, or for a long stretch when asked to.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic offer_item(input logic kind, input logic [31:0] now,
                             input logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] levels,
                             input logic deforced);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_now_us <= now;
      req_levels <= levels;
      req_deforced_mode <= deforced;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [LIMIT_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input logic [LIMIT_BITS-1:0] t, input logic [LEVEL_BITS-1:0] w,
                            input logic [LEVEL_BITS-1:0] l, input logic [LEVEL_BITS-1:0] b);
      time_lim = t;
      wheel_lim = w;
      leg_lim = l;
      tilt_lim = b;
      write_reg(CSR_TIME_LIMIT, t);
      write_reg(CSR_WHEEL_LIMIT, {5'd0, w});
      write_reg(CSR_LEG_LIMIT, {5'd0, l});
      write_reg(CSR_TILT_LIMIT, {5'd0, b});
   endtask

   function automatic logic [LEVEL_BITS-1:0] channel_limit(input int c);
      case (c)
         CH_LEFT_WHEEL, CH_RIGHT_WHEEL: return wheel_lim;
         CH_LEFT_LEG, CH_RIGHT_LEG:     return leg_lim;
         default:                       return tilt_lim;
      endcase
   endfunction

   // Levels mostly sit just above or just below the limit of the channel.
   function automatic logic [SAMPLE_BITS-1:0] make_level(input logic [LEVEL_BITS-1:0] limit,
                                                         input logic hot_ch);
      int mag;
      int spread;
      spread = limit / 8 + 2;
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return hot_ch ? 16'h8000 : 16'h0000;
         2: return $urandom_range(1) ? 16'h7FFF : 16'h8001;
         default: begin
            if (hot_ch) begin
               mag = limit + 1 + $urandom_range(spread);
            end else begin
               mag = limit - $urandom_range((limit < spread) ? limit : spread);
            end
            if (mag >= 32768) begin
               return 16'h8000;
            end
            return $urandom_range(1) ? 16'(-mag) : 16'(mag);
         end
      endcase
   endfunction

   function automatic logic [31:0] next_gap(input logic [LIMIT_BITS-1:0] limit);
      case ($urandom_range(29))
         0: return $urandom;
         1: return {limit, 1'b0} + 1;
         2: return {limit, 1'b0};
         3: return '0;
         default: return $urandom_range(limit / 3 + 1);
      endcase
   endfunction

   task automatic offer_random_item();
      logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] levels;
      logic                                     kind;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if ($urandom_range(99) < 12) begin
            hot[c] = ~hot[c];
         end
         levels[c] = make_level(channel_limit(c), hot[c]);
      end
      kind = ($urandom_range(99) < 3) ? KIND_RESET : KIND_CHECK;
      stim_now = stim_now + next_gap(time_lim);
      offer_item(kind, stim_now, levels, $urandom_range(99) < 25);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset limits.
      offer_item(KIND_CHECK, 32'd1000, {NUM_CHANNELS{16'h8000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd4000, {NUM_CHANNELS{16'h8000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd7000, {NUM_CHANNELS{16'h8000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd12000, {NUM_CHANNELS{16'h8000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd13000, {NUM_CHANNELS{16'h8000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd18000, {16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
                 1'b1);
      offer_item(KIND_CHECK, 32'd18001, {NUM_CHANNELS{16'h0000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd28001, {16'h0000, 16'd5121, 16'd5120, 16'h0000, 16'h0000},
                 1'b0);
      offer_item(KIND_CHECK, 32'd48001, {NUM_CHANNELS{16'h0000}}, 1'b0);
      offer_item(KIND_CHECK, 32'd68002, {NUM_CHANNELS{16'h8000}}, 1'b0);
      offer_item(KIND_RESET, 32'd70000, {NUM_CHANNELS{16'hFFFF}}, 1'b1);
      offer_item(KIND_CHECK, 32'hFFFF_F000, {NUM_CHANNELS{16'h0000}}, 1'b0);
      offer_item(KIND_CHECK, 32'h0000_0F00, {NUM_CHANNELS{16'h7FFF}}, 1'b0);
      offer_item(KIND_CHECK, 32'h0000_1AB8, {NUM_CHANNELS{16'h7FFF}}, 1'b0);
      offer_item(KIND_CHECK, 32'h0000_1B1C, {16'd313, 16'hEC00, 16'd5120, 16'hD800, 16'd10240},
                 1'b0);
      offer_item(KIND_RESET, 32'h0000_2000, {NUM_CHANNELS{16'h0000}}, 1'b0);
      offer_item(KIND_CHECK, 32'h0000_2000, {NUM_CHANNELS{16'h8000}}, 1'b0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         case (p)
            0: configure(TIME_LIMIT_RESET, WHEEL_LIMIT_RESET, LEG_LIMIT_RESET,
                         TILT_LIMIT_RESET);
            1: configure(20'd1, 15'd0, 15'd0, 15'd0);
            2: configure(20'hFFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
            3: configure(20'd0, 15'd100, 15'd200, 15'd300);
            4: configure(20'd1000000, 15'd8000, 15'd4000, 15'd1000);
            5: configure(LIMIT_BITS'($urandom_range(2000, 2)),
                         LEVEL_BITS'($urandom_range(32767)),
                         LEVEL_BITS'($urandom_range(32767)),
                         LEVEL_BITS'($urandom_range(32767)));
            6: configure(20'd500, 15'h7FFF, 15'd0, 15'd16384);
            default: configure(LIMIT_BITS'($urandom_range(20'hFFFFF)),
                               LEVEL_BITS'($urandom_range(32767)),
                               LEVEL_BITS'($urandom_range(32767)),
                               LEVEL_BITS'($urandom_range(32767)));
         endcase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         stim_now = p[0] ? 32'hFFFF_FFFF - $urandom_range(3000000) : $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 30) begin
               hold_toggle = ~hold_toggle;
            end
            offer_random_item();
         end
      end
      drain();

      $display("Covered %0d items and %0d reports over %0d limit settings and four idle mixes,",
               items_seen, results_seen, PHASE_COUNT);
      $display("including a %0d-cycle receiver hold-off that backed up the input.",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/itmu_pkg.sv
hdl/itmu_channel.sv
hdl/instability_time_monitor_unit.sv
hdl/itmu_checker.sv
sim/instability_time_monitor_unit_checker.sv
sim/instability_time_monitor_unit_tb.sv
